### hdl/pmlt_pkg.sv
// ============================================================================
// pmlt_pkg
// Shared types, constants and codes for the primary-sample mutator.
// ============================================================================
package pmlt_pkg;

    localparam int unsigned DefMaxSequences = 16;
    localparam int unsigned DefMaxSamples   = 64;

    localparam logic [15:0] SigmaReset = 16'd655;
    localparam logic [15:0] ProbReset  = 16'd19661;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_NEWSEQ = 3'd1,
        OP_NEXT   = 3'd2,
        OP_ACCEPT = 3'd3,
        OP_REJECT = 3'd4
    } t_opcode;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SEQ_OVF = 2'd1;
    localparam logic [1:0] ST_SMP_OVF = 2'd2;

    localparam logic [0:0] CFG_SIGMA = 1'b0;
    localparam logic [0:0] CFG_PROB  = 1'b1;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [23:0]        uniform_first;
        logic [23:0]        uniform_second;
        logic signed [23:0] gaussian_noise;
    } t_in_req;

    typedef struct packed {
        logic [23:0] sample_value;
        logic [1:0]  status;
    } t_out_req;

    // One table entry: value and checkpoint, kept together in one word.
    typedef struct packed {
        logic [23:0] entry_value;
        logic [31:0] entry_iteration;
        logic [23:0] saved_value;
        logic [31:0] saved_iteration;
    } t_entry;

    localparam int unsigned EntryW = $bits(t_entry);

    // Handshake between control and the square-root unit.
    typedef struct packed {
        logic        start;
        logic [47:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [23:0] root;
    } t_sqrt_rsp;

endpackage

### hdl/pss_mlt_sample_mutator.sv
// ============================================================================
// pss_mlt_sample_mutator
// Primary-sample-space Metropolis sample table: start, new sequence,
// draw (mutate) sample, accept and reject over a memory-held table.
// ============================================================================
// channel   | dir | handshake           | payload
// request   | in  | i_valid / o_stall   | i_req  (t_in_req)
// result    | out | o_valid / i_stall   | o_res  (t_out_req)
// config    | in  | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Start, new sequence, accept and unknown codes go straight to the result
// register; next sample reads the entry and, with a small step, waits for the
// square root and then runs two multiply stages. Reject sweeps the table
// entry by entry (read, check, write back).
// After reset a clearing pass writes every entry before the first request
// is taken. A stalled result holds; the next request is taken once the
// result register is free.
// ============================================================================
module pss_mlt_sample_mutator
    import pmlt_pkg::*;
#(
    parameter int unsigned MAX_SEQUENCES = DefMaxSequences,
    parameter int unsigned MAX_SAMPLES   = DefMaxSamples
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_req     i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_req    o_res,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int unsigned Depth = MAX_SEQUENCES * MAX_SAMPLES;
    localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned RamD  = 1 << AW;
    localparam int unsigned SeqW  = $clog2(MAX_SEQUENCES + 2);
    localparam int unsigned SmpW  = $clog2(MAX_SAMPLES + 2);
    localparam logic [SeqW-1:0] SeqTop = SeqW'(MAX_SEQUENCES);
    localparam logic [SmpW-1:0] SmpTop = SmpW'(MAX_SAMPLES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_MUT, S_SQRT, S_MUL1, S_MUL2, S_WB,
        S_RJ_RD, S_RJ_WAIT, S_RJ_WB, S_OUT
    } t_state;

    t_state             r_state;
    logic [15:0]        r_sigma, r_prob;
    logic [31:0]        r_cur_it, r_last_large;
    logic               r_large;
    logic [SmpW-1:0]    r_smp;
    logic [SeqW-1:0]    r_seq;
    logic [AW-1:0]      r_addr;
    logic               r_we;
    t_entry             r_wdata;
    t_entry             w_rdata;
    t_entry             r_ent;
    t_in_req            r_req;
    logic [39:0]        r_scale;
    logic [39:0]        w_scale;
    logic signed [20:0] w_scale_lo;
    logic signed [44:0] r_prod_lo;
    logic [23:0]        r_prod_hi;
    logic [23:0]        w_delta;
    logic [23:0]        w_new_val;
    t_sqrt_req          w_sq_req;
    t_sqrt_rsp          w_sq_rsp;
    logic               r_sq_start;
    logic [31:0]        r_age;
    logic               w_acc;
    logic [AW-1:0]      w_idx;
    logic [1:0]         w_status;
    t_entry             n_ent;
    t_entry             n_wdata;
    logic               n_we;

    assign o_stall = (r_state != S_IDLE) || o_valid;
    assign w_acc   = i_valid && !o_stall;

    // Table index of the sample just counted.
    assign w_idx = AW'((32'(r_seq) - 32'd1) * 32'(MAX_SAMPLES) + 32'(r_smp) - 32'd1);

    assign w_sq_req = '{start: r_sq_start, radicand: {r_age, 16'd0}};

    // scale * gaussian is split at bit 20 of scale; only bits [43:20]
    // of the full product are kept, so the high half needs its low 24 bits.
    assign w_scale    = 40'(r_sigma) * 40'(w_sq_rsp.root);
    assign w_scale_lo = {1'b0, r_scale[19:0]};
    assign w_delta    = r_prod_hi + r_prod_lo[43:20];
    assign w_new_val  = r_large ? r_ent.entry_value : r_ent.entry_value + w_delta;

    pmlt_ram #(.WIDTH(EntryW), .DEPTH(RamD)) u_table (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_addr  (r_addr),
        .i_wdata (r_wdata),
        .o_rdata (w_rdata)
    );

    pmlt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sq_req),
        .o_rsp   (w_sq_rsp)
    );

    // Status of an incoming request, from the counters before it.
    always_comb begin
        w_status = ST_OK;
        case (i_req.opcode)
            OP_NEWSEQ: begin
                if (r_seq >= SeqTop) begin
                    w_status = ST_SEQ_OVF;
                end
            end
            OP_NEXT: begin
                if (r_seq == '0 || r_seq > SeqTop) begin
                    w_status = ST_SEQ_OVF;
                end else if (r_smp >= SmpTop) begin
                    w_status = ST_SMP_OVF;
                end
            end
            default: ;
        endcase
    end

    // Fast-forward a stale entry, checkpoint it, then apply a large step if r_large is set.
    always_comb begin
        n_ent = w_rdata;
        if (w_rdata.entry_iteration < r_last_large) begin
            n_ent.entry_iteration = r_last_large;
            n_ent.entry_value     = r_req.uniform_first;
        end
        n_ent.saved_value     = n_ent.entry_value;
        n_ent.saved_iteration = n_ent.entry_iteration;
        if (r_large) begin
            n_ent.entry_value = r_req.uniform_second;
        end
    end

    // Table write for the next cycle: clearing, write back, rewind.
    always_comb begin
        n_we    = 1'b0;
        n_wdata = '0;
        case (r_state)
            S_CLEAR: n_we = (r_addr != AW'(RamD - 1));
            S_WB: begin
                n_we                    = 1'b1;
                n_wdata                 = r_ent;
                n_wdata.entry_iteration = r_cur_it;
                n_wdata.entry_value     = w_new_val;
            end
            S_RJ_WB: begin
                if (w_rdata.entry_iteration == r_cur_it) begin
                    n_we                    = 1'b1;
                    n_wdata                 = w_rdata;
                    n_wdata.entry_value     = w_rdata.saved_value;
                    n_wdata.entry_iteration = w_rdata.saved_iteration;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_sigma      <= SigmaReset;
            r_prob       <= ProbReset;
            r_cur_it     <= '0;
            r_last_large <= '0;
            r_large      <= 1'b0;
            r_smp        <= '0;
            r_seq        <= '0;
            r_addr       <= '0;
            r_we         <= 1'b1;
            r_wdata      <= '0;
            r_sq_start   <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_we       <= n_we;
            r_wdata    <= n_wdata;
            r_sq_start <= (r_state == S_SQRT) && !r_large;
            if (r_state == S_OUT) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SIGMA: r_sigma <= i_cfg_data;
                    CFG_PROB:  r_prob  <= i_cfg_data;
                    default:   ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == AW'(RamD - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_req              <= i_req;
                        o_res.sample_value <= '0;
                        o_res.status       <= w_status;
                        case (i_req.opcode)
                            OP_START: begin
                                r_cur_it <= r_cur_it + 32'd1;
                                r_large  <= i_req.uniform_first < {r_prob, 8'd0};
                                r_smp    <= '0;
                                r_seq    <= '0;
                                r_state  <= S_OUT;
                            end
                            OP_NEWSEQ: begin
                                r_smp <= '0;
                                if (r_seq <= SeqTop) begin
                                    r_seq <= r_seq + SeqW'(1);
                                end
                                r_state <= S_OUT;
                            end
                            OP_NEXT: begin
                                if (r_seq != '0 && r_seq <= SeqTop && r_smp <= SmpTop) begin
                                    r_smp <= r_smp + SmpW'(1);
                                end
                                r_state <= (w_status == ST_OK) ? S_RD : S_OUT;
                            end
                            OP_ACCEPT: begin
                                if (r_large) begin
                                    r_last_large <= r_cur_it;
                                end
                                r_state <= S_OUT;
                            end
                            OP_REJECT: begin
                                r_addr  <= '0;
                                r_state <= S_RJ_WAIT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_RD: begin
                    r_addr  <= w_idx;
                    r_state <= S_MUT;
                end
                S_MUT: r_state <= S_SQRT;
                S_SQRT: begin
                    // read data valid now
                    r_ent   <= n_ent;
                    r_age   <= r_cur_it - n_ent.entry_iteration;
                    r_state <= r_large ? S_WB : S_MUL1;
                end
                S_MUL1: begin
                    if (w_sq_rsp.done) begin
                        r_scale <= w_scale;
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_prod_lo <= 45'(w_scale_lo) * 45'(r_req.gaussian_noise);
                    r_prod_hi <= {4'd0, r_scale[39:20]} * $unsigned(r_req.gaussian_noise);
                    r_state   <= S_WB;
                end
                S_WB: begin
                    o_res.sample_value <= w_new_val;
                    r_state            <= S_OUT;
                end
                // the rewind of the previous entry is written in this cycle
                S_RJ_RD: begin
                    r_addr  <= r_addr + AW'(1);
                    r_state <= S_RJ_WAIT;
                end
                S_RJ_WAIT: r_state <= S_RJ_WB;
                S_RJ_WB: begin
                    if (r_addr == AW'(Depth - 1)) begin
                        r_cur_it <= r_cur_it - 32'd1;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_RJ_RD;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_state != S_IDLE)
        else $error("request taken but control stayed idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_valid)
        else $error("result not raised");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_rsp.done |-> $past(r_state) == S_MUL1)
        else $error("square root finished outside a small step");
endmodule

### hdl/pmlt_ram.sv
// ============================================================================
// pmlt_ram
// Generic single-port synchronous RAM with registered read.
// ============================================================================
module pmlt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/pmlt_sqrt.sv
// ============================================================================
// pmlt_sqrt
// Iterative integer square root, one result bit per cycle.
// ============================================================================
module pmlt_sqrt
    import pmlt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [47:0] r_x;
    logic [25:0] r_rem;
    logic [23:0] r_root;
    logic [25:0] n_trial;
    logic [25:0] n_rem;

    // Restoring method: bring down two radicand bits each step.
    always_comb begin
        n_rem   = {r_rem[23:0], r_x[47:46]};
        n_trial = n_rem - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_req.radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_x <= {r_x[45:0], 2'b00};
                if (!n_trial[25]) begin
                    r_rem  <= n_trial;
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[22:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy <= 1'b0;
                end
                r_done <= (r_cnt == 5'd23);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp = '{done: r_done, root: r_root};
endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: pss_mlt_sample_mutator testbench
// Drives start/sequence/draw/accept/reject and unknown-code requests with random idling on
// both channels, predicts every result with a local sample-table model and
// checks results in order. Register writes happen only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import pmlt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEQ  = DefMaxSequences;
    localparam int NSMP  = DefMaxSamples;
    localparam int DEPTH = NSEQ * NSMP;

    // sample table predictor and queue of expected results
    class mutator_scoreboard;
        logic [23:0] val_q[DEPTH];
        logic [31:0] itr_q[DEPTH];
        logic [23:0] sv_val[DEPTH];
        logic [31:0] sv_itr[DEPTH];
        logic [31:0] cur_iter, last_large;
        bit          large_flag;
        int unsigned smp_cnt, seq_cnt;
        logic [15:0] sigma, prob;
        t_out_req    pending[$];
        int          errors;

        function void clear();
            for (int i = 0; i < DEPTH; i++) begin
                val_q[i] = '0; itr_q[i] = '0; sv_val[i] = '0; sv_itr[i] = '0;
            end
            cur_iter = '0; last_large = '0; large_flag = 0;
            smp_cnt = 0; seq_cnt = 0;
            sigma = SigmaReset; prob = ProbReset;
            errors = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] r, b;
            r = 0; b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b; r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [23:0] mutate(t_in_req rq, output logic [1:0] st);
            int unsigned k;
            logic [31:0] age;
            logic [63:0] root, scale, g, p;
            st = ST_OK;
            if (seq_cnt == 0 || seq_cnt > NSEQ) begin
                st = ST_SEQ_OVF;
                return '0;
            end
            if (smp_cnt <= NSMP) smp_cnt++;
            if (smp_cnt > NSMP) begin
                st = ST_SMP_OVF;
                return '0;
            end
            k = (seq_cnt - 1) * NSMP + (smp_cnt - 1);
            if (itr_q[k] < last_large) begin
                itr_q[k] = last_large;
                val_q[k] = rq.uniform_first;
            end
            sv_val[k] = val_q[k];
            sv_itr[k] = itr_q[k];
            if (large_flag) begin
                val_q[k] = rq.uniform_second;
            end else begin
                age   = cur_iter - itr_q[k];
                root  = int_sqrt({16'd0, age, 16'd0});
                scale = 64'(sigma) * root;
                g     = {{40{rq.gaussian_noise[23]}}, rq.gaussian_noise};
                p     = scale * g;
                val_q[k] = val_q[k] + p[43:20];
            end
            itr_q[k] = cur_iter;
            return val_q[k];
        endfunction

        function void note_request(t_in_req rq);
            t_out_req r;
            r = '0;
            case (rq.opcode)
                OP_START: begin
                    cur_iter++;
                    large_flag = rq.uniform_first < {prob, 8'd0};
                    smp_cnt = 0; seq_cnt = 0;
                end
                OP_NEWSEQ: begin
                    smp_cnt = 0;
                    if (seq_cnt <= NSEQ) seq_cnt++;
                    if (seq_cnt > NSEQ) r.status = ST_SEQ_OVF;
                end
                OP_NEXT: r.sample_value = mutate(rq, r.status);
                OP_ACCEPT: if (large_flag) last_large = cur_iter;
                OP_REJECT: begin
                    for (int i = 0; i < DEPTH; i++)
                        if (itr_q[i] == cur_iter) begin
                            val_q[i] = sv_val[i]; itr_q[i] = sv_itr[i];
                        end
                    cur_iter--;
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(t_out_req got);
            t_out_req exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.sample_value !== exp_r.sample_value) begin
                $error("sample_value exp %h got %h", exp_r.sample_value, got.sample_value);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status exp %0d got %0d", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    t_in_req     req;
    t_out_req    res;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    int          send_idle_pct, recv_idle_pct;
    mutator_scoreboard sb;

    pss_mlt_sample_mutator uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_req(req),
        .o_valid(out_valid), .i_stall(out_stall), .o_res(res),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // result side: random stall, check on accept
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(res);
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send(t_in_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req      <= rq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(rq);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        drop_valid();
        while (sb.pending.size() != 0) @(posedge clk);
        // quiet gap before register writes
        repeat (2 * DEPTH + 50) @(posedge clk);
    endtask

    // writes both registers on consecutive edges
    task automatic write_regs(logic [15:0] sigma, logic [15:0] prob);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIGMA;
        cfg_data  <= sigma;
        @(posedge clk);
        cfg_index <= CFG_PROB;
        cfg_data  <= prob;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.sigma = sigma;
        sb.prob  = prob;
    endtask

    function automatic t_in_req make_req(t_opcode op);
        t_in_req rq;
        rq.opcode         = op;
        rq.uniform_first  = 24'($urandom);
        rq.uniform_second = 24'($urandom);
        rq.gaussian_noise = 24'($urandom);
        return rq;
    endfunction

    // one iteration: start, sequences of draws, then accept or reject
    task automatic run_iteration(int nseq, int nsmp);
        send(make_req(OP_START));
        for (int s = 0; s < nseq; s++) begin
            send(make_req(OP_NEWSEQ));
            for (int k = 0; k < nsmp; k++) send(make_req(OP_NEXT));
        end
        if ($urandom_range(1)) send(make_req(OP_ACCEPT));
        else send(make_req(OP_REJECT));
    endtask

    task automatic random_phase(int count);
        t_in_req rq;
        int n;
        int nseq, nsmp;
        n = 0;
        while (n < count) begin
            if ($urandom_range(9) < 8) begin
                nseq = $urandom_range(1, 3);
                nsmp = $urandom_range(0, 6);
                run_iteration(nseq, nsmp);
                n += 2 + nseq * (1 + nsmp);
            end else begin
                rq = make_req(OP_START);
                rq.opcode = 3'($urandom_range(7));
                send(rq);
                n++;
            end
        end
    endtask

    initial begin
        t_in_req rq;
        sb = new();
        sb.clear();
        rst_n = 0; in_valid = 0; out_stall = 0; req = '0;
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        send_idle_pct = 33; recv_idle_pct = 62;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: overflow cases, extremes, all opcodes
        send(make_req(OP_NEXT));            // no open sequence
        rq = make_req(OP_START); rq.uniform_first = '0; send(rq);
        send(make_req(OP_NEXT));
        rq = make_req(OP_NEWSEQ); send(rq);
        rq = make_req(OP_NEXT); rq.uniform_second = '1; send(rq);
        send(make_req(OP_ACCEPT));
        rq = make_req(OP_START); rq.uniform_first = '1; send(rq);
        send(make_req(OP_NEWSEQ));
        rq = make_req(OP_NEXT); rq.gaussian_noise = 24'h7FFFFF; send(rq);
        rq = make_req(OP_NEXT); rq.gaussian_noise = 24'h800000; send(rq);
        send(make_req(OP_REJECT));
        for (int i = 0; i < 4; i++) send(make_req(OP_REJECT)); // wrap below zero
        rq = make_req(OP_START); rq.opcode = 3'd5; send(rq);
        rq.opcode = 3'd7; send(rq);
        for (int i = 0; i < 4; i++) send(make_req(OP_START));
        // sample index overflow
        send(make_req(OP_START));
        send(make_req(OP_NEWSEQ));
        for (int i = 0; i < NSMP + 2; i++) send(make_req(OP_NEXT));
        // sequence index overflow
        for (int i = 0; i < NSEQ + 2; i++) send(make_req(OP_NEWSEQ));
        send(make_req(OP_NEXT));
        send(make_req(OP_ACCEPT));
        wait_drain();

        write_regs(16'hFFFF, 16'd0);
        random_phase(500);
        wait_drain();

        write_regs(16'd0, 16'hFFFF);
        send_idle_pct = 62; recv_idle_pct = 33;
        random_phase(500);
        wait_drain();

        write_regs(16'($urandom), 16'h8000);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(650);
        wait_drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
